// ----- src/pemu_pkg.sv -----
// ---------------------------------------------------------------------------
// pemu_pkg: shared types, constants and helpers for the pose update pipeline
// Holds the item record that travels down the cell chains, the fixed-point
// constants and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
package pemu_pkg;

   localparam int VAL_W        = 48;
   localparam int FRAC_W       = 32;
   localparam int TRIG_ITER    = 32;
   localparam int SQ1_CELLS    = 48;
   localparam int SQ2_CELLS    = 64;
   localparam int MOD_STEPS    = 14;
   localparam int DIV_CELLS    = 33;
   localparam int QW           = 34;

   localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
   localparam logic [63:0] TWO_PI_Q60  = PI_Q60 << 1;
   localparam logic [63:0] HALF_PI_Q60 = PI_Q60 >> 1;
   localparam logic [63:0] ONE_Q60     = 64'h1000000000000000;
   // 2*pi in Q.32, rounded to nearest
   localparam logic [63:0] TWO_PI_QF   = (PI_Q60 + 64'h0000000004000000) >> 27;

   localparam logic signed [63:0] VAL_MAX = 64'sd140737488355327;
   localparam logic signed [63:0] VAL_MIN = -64'sd140737488355328;

   // Hamilton product q * a: source index and negation per output and term
   localparam logic [1:0] PROD_IDX [4][4] = '{
      '{2'd0, 2'd1, 2'd2, 2'd3},
      '{2'd1, 2'd0, 2'd3, 2'd2},
      '{2'd2, 2'd3, 2'd0, 2'd1},
      '{2'd3, 2'd2, 2'd1, 2'd0}};
   localparam logic [3:0] PROD_NEG [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

   typedef logic [63:0] atan_tab_type [TRIG_ITER];

   typedef struct packed {
      logic                   func;
      logic [3:0][VAL_W-1:0]  a;
      logic [2:0][VAL_W-1:0]  d;
      logic [127:0]           rad;
      logic [65:0]            srem;
      logic [63:0]            root;
      logic [VAL_W-1:0]       n;
      logic [63:0]            ang;
      logic                   neg_s;
      logic                   neg_c;
      logic [63:0]            cx;
      logic [63:0]            cy;
      logic [63:0]            cz;
      logic [63:0]            den;
      logic [2:0][63:0]       drem;
      logic [2:0][32:0]       dlow;
      logic [2:0][32:0]       quo;
      logic [3:0][QW-1:0]     q;
   } item_type;

   typedef struct packed {
      logic [VAL_W-1:0] val;
      logic             clip;
   } sat_type;

   // arctangent of 2^-i in Q.60: pi/4 first, then the truncated series
   function automatic atan_tab_type build_atan();
      atan_tab_type t;
      logic [63:0]  acc;
      logic [63:0]  term;
      int           i;
      int           k;
      t[0] = PI_Q60 >> 2;
      for (i = 1; i < TRIG_ITER; i++) begin
         acc = '0;
         for (k = 0; i * (2 * k + 1) <= 60; k++) begin
            term = (64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1);
            if ((k & 1) != 0) acc = acc - term;
            else acc = acc + term;
         end
         t[i] = acc;
      end
      return t;
   endfunction

   localparam atan_tab_type ATAN_TAB = build_atan();

   function automatic logic [VAL_W-1:0] mag_val(input logic [VAL_W-1:0] v);
      return v[VAL_W-1] ? (VAL_W'(0) - v) : v;
   endfunction

   function automatic logic [63:0] mag64(input logic [63:0] v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

   function automatic logic [QW-1:0] mag_q(input logic [QW-1:0] v);
      return v[QW-1] ? (QW'(0) - v) : v;
   endfunction

   function automatic sat_type sat_val(input logic signed [63:0] v);
      sat_type r;
      if (v > VAL_MAX) begin
         r.val  = VAL_MAX[VAL_W-1:0];
         r.clip = 1'b1;
      end else if (v < VAL_MIN) begin
         r.val  = VAL_MIN[VAL_W-1:0];
         r.clip = 1'b1;
      end else begin
         r.val  = v[VAL_W-1:0];
         r.clip = 1'b0;
      end
      return r;
   endfunction

endpackage

// ----- src/pemu_mul.sv -----
// ---------------------------------------------------------------------------
// pemu_mul: unsigned 64 x 64 multiplier, two stages
// Four 32 x 32 partial products in the first stage, their sum in the second.
// ---------------------------------------------------------------------------
module pemu_mul (
   input  logic          clock,
   input  logic          adv,
   input  logic [63:0]   op_a,
   input  logic [63:0]   op_b,
   output logic [127:0]  prod
);

   logic [63:0]  pp_ff [4];
   logic [127:0] prod_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         pp_ff[0] <= op_a[31:0]  * op_b[31:0];
         pp_ff[1] <= op_a[63:32] * op_b[31:0];
         pp_ff[2] <= op_a[31:0]  * op_b[63:32];
         pp_ff[3] <= op_a[63:32] * op_b[63:32];
         prod_ff  <= 128'(pp_ff[0]) + (128'(pp_ff[1]) << 32) + (128'(pp_ff[2]) << 32)
                   + (128'(pp_ff[3]) << 64);
      end
   end

   assign prod = prod_ff;

endmodule

// ----- src/pemu_sqrt_cell.sv -----
// ---------------------------------------------------------------------------
// pemu_sqrt_cell: one digit of a restoring integer square root
// Takes the next two radicand bits and decides one root bit.
// ---------------------------------------------------------------------------
module pemu_sqrt_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  pemu_pkg::item_type in_item,
   output logic               out_valid,
   output pemu_pkg::item_type out_item
);

   logic               valid_ff;
   pemu_pkg::item_type item_ff;
   pemu_pkg::item_type item_in;
   logic [67:0]        shifted;
   logic [67:0]        trial;

   always_comb begin
      item_in = in_item;
      shifted = {in_item.srem, in_item.rad[127:126]};
      trial   = {2'b00, in_item.root, 2'b01};
      if (shifted >= trial) begin
         item_in.srem = 66'(shifted - trial);
         item_in.root = {in_item.root[62:0], 1'b1};
      end else begin
         item_in.srem = shifted[65:0];
         item_in.root = {in_item.root[62:0], 1'b0};
      end
      item_in.rad = {in_item.rad[125:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (adv) valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ----- src/pemu_mod_cell.sv -----
// ---------------------------------------------------------------------------
// pemu_mod_cell: one step of the reduction modulo two pi
// Subtracts 2*pi scaled by 2^step when it fits.
// ---------------------------------------------------------------------------
module pemu_mod_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic [3:0]         step,
   input  logic               in_valid,
   input  pemu_pkg::item_type in_item,
   output logic               out_valid,
   output pemu_pkg::item_type out_item
);

   logic               valid_ff;
   pemu_pkg::item_type item_ff;
   pemu_pkg::item_type item_in;
   logic [63:0]        sub;

   always_comb begin
      item_in = in_item;
      sub     = pemu_pkg::TWO_PI_QF << step;
      if (in_item.ang >= sub) item_in.ang = in_item.ang - sub;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (adv) valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ----- src/pemu_cordic_cell.sv -----
// ---------------------------------------------------------------------------
// pemu_cordic_cell: one CORDIC rotation micro-step in Q.60
// Rotates (x, y) by +/- atan(2^-step) toward a zero residual angle.
// ---------------------------------------------------------------------------
module pemu_cordic_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic [4:0]         step,
   input  logic               in_valid,
   input  pemu_pkg::item_type in_item,
   output logic               out_valid,
   output pemu_pkg::item_type out_item
);

   logic               valid_ff;
   pemu_pkg::item_type item_ff;
   pemu_pkg::item_type item_in;
   logic [63:0]        dx;
   logic [63:0]        dy;

   always_comb begin
      item_in = in_item;
      dx = 64'($signed(in_item.cy) >>> step);
      dy = 64'($signed(in_item.cx) >>> step);
      if (in_item.cz[63]) begin
         item_in.cx = in_item.cx + dx;
         item_in.cy = in_item.cy - dy;
         item_in.cz = in_item.cz + pemu_pkg::ATAN_TAB[step];
      end else begin
         item_in.cx = in_item.cx - dx;
         item_in.cy = in_item.cy + dy;
         item_in.cz = in_item.cz - pemu_pkg::ATAN_TAB[step];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (adv) valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ----- src/pemu_div_cell.sv -----
// ---------------------------------------------------------------------------
// pemu_div_cell: one quotient bit of a restoring divider, three lanes
// All lanes share one divisor; each shifts in its next dividend bit.
// ---------------------------------------------------------------------------
module pemu_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  pemu_pkg::item_type in_item,
   output logic               out_valid,
   output pemu_pkg::item_type out_item
);

   logic               valid_ff;
   pemu_pkg::item_type item_ff;
   pemu_pkg::item_type item_in;
   logic [64:0]        part [3];

   always_comb begin
      item_in = in_item;
      for (int l = 0; l < 3; l++) begin
         part[l] = {in_item.drem[l], in_item.dlow[l][32]};
         if (part[l] >= {1'b0, in_item.den}) begin
            part[l] = part[l] - {1'b0, in_item.den};
            item_in.quo[l] = {in_item.quo[l][31:0], 1'b1};
         end else begin
            item_in.quo[l] = {in_item.quo[l][31:0], 1'b0};
         end
         item_in.drem[l] = part[l][63:0];
         item_in.dlow[l] = {in_item.dlow[l][31:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (adv) valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ----- src/pose_exp_map_update_top.sv -----
// ---------------------------------------------------------------------------
// pose_exp_map_update_top: pose increment through the quaternion exp map
// Translation add (func 0) or rotation-vector quaternion update (func 1).
// ---------------------------------------------------------------------------
// One request is taken every clock cycle while the output is not stalled;
// both item kinds take the same path through the pipe. The path is set by
// the chains of cells: two square roots (48 and 64 cells, one root bit each),
// the modulo 2*pi reduction (14 cells), 32 CORDIC cells and two 33-cell
// dividers, plus twenty registered stages for the products and sums. The
// whole pipe moves in lockstep and holds only while a result waits at the
// output under rsp_stall.
module pose_exp_map_update_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic signed [pemu_pkg::VAL_W-1:0] req_a0,
   input  logic signed [pemu_pkg::VAL_W-1:0] req_a1,
   input  logic signed [pemu_pkg::VAL_W-1:0] req_a2,
   input  logic signed [pemu_pkg::VAL_W-1:0] req_a3,
   input  logic signed [pemu_pkg::VAL_W-1:0] req_d0,
   input  logic signed [pemu_pkg::VAL_W-1:0] req_d1,
   input  logic signed [pemu_pkg::VAL_W-1:0] req_d2,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [pemu_pkg::VAL_W-1:0] rsp_r0,
   output logic signed [pemu_pkg::VAL_W-1:0] rsp_r1,
   output logic signed [pemu_pkg::VAL_W-1:0] rsp_r2,
   output logic signed [pemu_pkg::VAL_W-1:0] rsp_r3,
   output logic                          rsp_saturated
);

   localparam int VW = pemu_pkg::VAL_W;

   logic adv;

   logic [18:0]        sv_ff;
   logic [18:0]        sv_in;
   pemu_pkg::item_type st_ff [19];
   pemu_pkg::item_type st_in [19];

   logic               sq1_v  [pemu_pkg::SQ1_CELLS+1];
   pemu_pkg::item_type sq1_it [pemu_pkg::SQ1_CELLS+1];
   logic               mod_v  [pemu_pkg::MOD_STEPS+1];
   pemu_pkg::item_type mod_it [pemu_pkg::MOD_STEPS+1];
   logic               cor_v  [pemu_pkg::TRIG_ITER+1];
   pemu_pkg::item_type cor_it [pemu_pkg::TRIG_ITER+1];
   logic               sq2_v  [pemu_pkg::SQ2_CELLS+1];
   pemu_pkg::item_type sq2_it [pemu_pkg::SQ2_CELLS+1];
   logic               dv1_v  [pemu_pkg::DIV_CELLS+1];
   pemu_pkg::item_type dv1_it [pemu_pkg::DIV_CELLS+1];
   logic               dv2_v  [pemu_pkg::DIV_CELLS+1];
   pemu_pkg::item_type dv2_it [pemu_pkg::DIV_CELLS+1];

   logic [127:0] dsq_p [3];
   logic [127:0] xy_p  [2];
   logic [127:0] sd_p  [3];
   logic [127:0] hm_p  [4][4];

   logic signed [87:0] hp_ff [4][2];
   logic signed [87:0] hp_in [4][2];
   logic signed [87:0] term  [4][4];

   logic [96:0]  num_a [3];
   logic [96:0]  num_b [3];
   logic [63:0]  ang_r;
   logic [63:0]  ang_f;
   logic [32:0]  m_c;
   logic [32:0]  m_s;
   logic [QWL-1:0] vm [3];
   localparam int QWL = pemu_pkg::QW;

   logic                 rsp_valid_ff;
   logic [VW-1:0]        r_ff [4];
   logic [VW-1:0]        r_in [4];
   logic                 sat_ff;
   logic                 sat_in;
   logic signed [87:0]   acc  [4];
   logic signed [87:0]   rnd  [4];
   pemu_pkg::sat_type    rot_s [4];
   pemu_pkg::sat_type    tr_s  [3];

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // ---------------- cell chains
   assign sq1_v[0]  = sv_ff[3];
   assign sq1_it[0] = st_ff[3];
   assign mod_v[0]  = sv_ff[4];
   assign mod_it[0] = st_ff[4];
   assign cor_v[0]  = sv_ff[6];
   assign cor_it[0] = st_ff[6];
   assign sq2_v[0]  = sv_ff[9];
   assign sq2_it[0] = st_ff[9];
   assign dv1_v[0]  = sv_ff[10];
   assign dv1_it[0] = st_ff[10];
   assign dv2_v[0]  = sv_ff[14];
   assign dv2_it[0] = st_ff[14];

   for (genvar g = 0; g < pemu_pkg::SQ1_CELLS; g++) begin : g_sq1
      pemu_sqrt_cell u_cell (
         .clock, .reset, .adv,
         .in_valid(sq1_v[g]), .in_item(sq1_it[g]),
         .out_valid(sq1_v[g+1]), .out_item(sq1_it[g+1]));
   end

   for (genvar g = 0; g < pemu_pkg::MOD_STEPS; g++) begin : g_mod
      pemu_mod_cell u_cell (
         .clock, .reset, .adv,
         .step(4'(pemu_pkg::MOD_STEPS - 1 - g)),
         .in_valid(mod_v[g]), .in_item(mod_it[g]),
         .out_valid(mod_v[g+1]), .out_item(mod_it[g+1]));
   end

   for (genvar g = 0; g < pemu_pkg::TRIG_ITER; g++) begin : g_cor
      pemu_cordic_cell u_cell (
         .clock, .reset, .adv,
         .step(5'(g)),
         .in_valid(cor_v[g]), .in_item(cor_it[g]),
         .out_valid(cor_v[g+1]), .out_item(cor_it[g+1]));
   end

   for (genvar g = 0; g < pemu_pkg::SQ2_CELLS; g++) begin : g_sq2
      pemu_sqrt_cell u_cell (
         .clock, .reset, .adv,
         .in_valid(sq2_v[g]), .in_item(sq2_it[g]),
         .out_valid(sq2_v[g+1]), .out_item(sq2_it[g+1]));
   end

   for (genvar g = 0; g < pemu_pkg::DIV_CELLS; g++) begin : g_dv1
      pemu_div_cell u_cell (
         .clock, .reset, .adv,
         .in_valid(dv1_v[g]), .in_item(dv1_it[g]),
         .out_valid(dv1_v[g+1]), .out_item(dv1_it[g+1]));
   end

   for (genvar g = 0; g < pemu_pkg::DIV_CELLS; g++) begin : g_dv2
      pemu_div_cell u_cell (
         .clock, .reset, .adv,
         .in_valid(dv2_v[g]), .in_item(dv2_it[g]),
         .out_valid(dv2_v[g+1]), .out_item(dv2_it[g+1]));
   end

   // ---------------- multipliers
   for (genvar g = 0; g < 3; g++) begin : g_dsq
      pemu_mul u_mul (
         .clock, .adv,
         .op_a(64'(pemu_pkg::mag_val(st_ff[0].d[g]))),
         .op_b(64'(pemu_pkg::mag_val(st_ff[0].d[g]))),
         .prod(dsq_p[g]));
   end

   pemu_mul u_mul_xx (
      .clock, .adv,
      .op_a(pemu_pkg::mag64(cor_it[pemu_pkg::TRIG_ITER].cx)),
      .op_b(pemu_pkg::mag64(cor_it[pemu_pkg::TRIG_ITER].cx)),
      .prod(xy_p[0]));

   pemu_mul u_mul_yy (
      .clock, .adv,
      .op_a(pemu_pkg::mag64(cor_it[pemu_pkg::TRIG_ITER].cy)),
      .op_b(pemu_pkg::mag64(cor_it[pemu_pkg::TRIG_ITER].cy)),
      .prod(xy_p[1]));

   for (genvar g = 0; g < 3; g++) begin : g_sd
      pemu_mul u_mul (
         .clock, .adv,
         .op_a(64'(st_ff[11].quo[1])),
         .op_b(64'(pemu_pkg::mag_val(st_ff[11].d[g]))),
         .prod(sd_p[g]));
   end

   for (genvar gi = 0; gi < 4; gi++) begin : g_hi
      for (genvar gj = 0; gj < 4; gj++) begin : g_hj
         pemu_mul u_mul (
            .clock, .adv,
            .op_a(64'(pemu_pkg::mag_q(st_ff[15].q[gj]))),
            .op_b(64'(pemu_pkg::mag_val(st_ff[15].a[pemu_pkg::PROD_IDX[gi][gj]]))),
            .prod(hm_p[gi][gj]));
      end
   end

   // ---------------- stage logic
   always_comb begin
      sv_in[0]  = req_valid;
      sv_in[1]  = sv_ff[0];
      sv_in[2]  = sv_ff[1];
      sv_in[3]  = sv_ff[2];
      sv_in[4]  = sq1_v[pemu_pkg::SQ1_CELLS];
      sv_in[5]  = mod_v[pemu_pkg::MOD_STEPS];
      sv_in[6]  = sv_ff[5];
      sv_in[7]  = cor_v[pemu_pkg::TRIG_ITER];
      sv_in[8]  = sv_ff[7];
      sv_in[9]  = sv_ff[8];
      sv_in[10] = sq2_v[pemu_pkg::SQ2_CELLS];
      sv_in[11] = dv1_v[pemu_pkg::DIV_CELLS];
      sv_in[12] = sv_ff[11];
      sv_in[13] = sv_ff[12];
      sv_in[14] = sv_ff[13];
      sv_in[15] = dv2_v[pemu_pkg::DIV_CELLS];
      sv_in[16] = sv_ff[15];
      sv_in[17] = sv_ff[16];
      sv_in[18] = sv_ff[17];
   end

   always_comb begin
      // capture the request
      st_in[0]      = '0;
      st_in[0].func = req_func;
      st_in[0].a[0] = req_a0;
      st_in[0].a[1] = req_a1;
      st_in[0].a[2] = req_a2;
      st_in[0].a[3] = req_a3;
      st_in[0].d[0] = req_d0;
      st_in[0].d[1] = req_d1;
      st_in[0].d[2] = req_d2;

      st_in[1] = st_ff[0];
      st_in[2] = st_ff[1];

      // squared norm, left-justified so 48 root digits consume it exactly
      st_in[3]      = st_ff[2];
      st_in[3].rad  = {dsq_p[0][95:0] + dsq_p[1][95:0] + dsq_p[2][95:0], 32'd0};
      st_in[3].srem = '0;
      st_in[3].root = '0;

      st_in[4]     = sq1_it[pemu_pkg::SQ1_CELLS];
      st_in[4].n   = sq1_it[pemu_pkg::SQ1_CELLS].root[VW-1:0];
      st_in[4].ang = 64'(sq1_it[pemu_pkg::SQ1_CELLS].root[VW-1:0]);

      // residue to Q.60, one fold below two pi
      ang_r = {mod_it[pemu_pkg::MOD_STEPS].ang[35:0], 28'd0};
      if (ang_r >= pemu_pkg::TWO_PI_Q60) ang_r = ang_r - pemu_pkg::TWO_PI_Q60;
      st_in[5]     = mod_it[pemu_pkg::MOD_STEPS];
      st_in[5].ang = ang_r;

      // fold into the first quadrant, noting sign flips
      st_in[6]       = st_ff[5];
      ang_f          = st_ff[5].ang;
      st_in[6].neg_s = 1'b0;
      st_in[6].neg_c = 1'b0;
      if (ang_f > pemu_pkg::PI_Q60) begin
         ang_f          = pemu_pkg::TWO_PI_Q60 - ang_f;
         st_in[6].neg_s = 1'b1;
      end
      if (ang_f > pemu_pkg::HALF_PI_Q60) begin
         ang_f          = pemu_pkg::PI_Q60 - ang_f;
         st_in[6].neg_c = 1'b1;
      end
      st_in[6].ang = ang_f;
      st_in[6].cx  = pemu_pkg::ONE_Q60;
      st_in[6].cy  = '0;
      st_in[6].cz  = ang_f;

      st_in[7] = cor_it[pemu_pkg::TRIG_ITER];
      st_in[8] = st_ff[7];

      st_in[9]      = st_ff[8];
      st_in[9].rad  = xy_p[0] + xy_p[1];
      st_in[9].srem = '0;
      st_in[9].root = '0;

      // gain removal: round(|x| * 2^F / len), same for y
      st_in[10]     = sq2_it[pemu_pkg::SQ2_CELLS];
      st_in[10].den = sq2_it[pemu_pkg::SQ2_CELLS].root;
      num_a[0] = {1'b0, pemu_pkg::mag64(sq2_it[pemu_pkg::SQ2_CELLS].cx), 32'd0}
               + 97'(sq2_it[pemu_pkg::SQ2_CELLS].root >> 1);
      num_a[1] = {1'b0, pemu_pkg::mag64(sq2_it[pemu_pkg::SQ2_CELLS].cy), 32'd0}
               + 97'(sq2_it[pemu_pkg::SQ2_CELLS].root >> 1);
      num_a[2] = '0;
      for (int l = 0; l < 3; l++) begin
         st_in[10].drem[l] = num_a[l][96:33];
         st_in[10].dlow[l] = num_a[l][32:0];
         st_in[10].quo[l]  = '0;
      end

      // signed cosine and sine in Q.F
      st_in[11] = dv1_it[pemu_pkg::DIV_CELLS];
      m_c = dv1_it[pemu_pkg::DIV_CELLS].quo[0];
      m_s = dv1_it[pemu_pkg::DIV_CELLS].quo[1];
      st_in[11].q[0] = (dv1_it[pemu_pkg::DIV_CELLS].cx[63] ^ dv1_it[pemu_pkg::DIV_CELLS].neg_c)
                     ? (QWL'(0) - {1'b0, m_c}) : {1'b0, m_c};
      st_in[11].q[1] = (dv1_it[pemu_pkg::DIV_CELLS].cy[63] ^ dv1_it[pemu_pkg::DIV_CELLS].neg_s)
                     ? (QWL'(0) - {1'b0, m_s}) : {1'b0, m_s};

      st_in[12] = st_ff[11];
      st_in[13] = st_ff[12];

      // vector part: round(|s| * |d_i| / n)
      st_in[14]     = st_ff[13];
      st_in[14].den = 64'(st_ff[13].n);
      for (int l = 0; l < 3; l++) begin
         num_b[l] = sd_p[l][96:0] + 97'(st_ff[13].n >> 1);
         st_in[14].drem[l] = num_b[l][96:33];
         st_in[14].dlow[l] = num_b[l][32:0];
         st_in[14].quo[l]  = '0;
      end

      st_in[15] = dv2_it[pemu_pkg::DIV_CELLS];
      for (int l = 0; l < 3; l++) begin
         vm[l] = {1'b0, dv2_it[pemu_pkg::DIV_CELLS].quo[l]};
         st_in[15].q[l+1] = (dv2_it[pemu_pkg::DIV_CELLS].q[1][QWL-1]
                           ^ dv2_it[pemu_pkg::DIV_CELLS].d[l][VW-1])
                          ? (QWL'(0) - vm[l]) : vm[l];
      end

      st_in[16] = st_ff[15];
      st_in[17] = st_ff[16];
      st_in[18] = st_ff[17];
   end

   // signed Hamilton terms, summed in pairs
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            term[i][j] = (st_ff[17].q[j][QWL-1]
                        ^ st_ff[17].a[pemu_pkg::PROD_IDX[i][j]][VW-1]
                        ^ pemu_pkg::PROD_NEG[i][j])
                       ? (88'sd0 - $signed(hm_p[i][j][87:0])) : $signed(hm_p[i][j][87:0]);
         end
         hp_in[i][0] = term[i][0] + term[i][1];
         hp_in[i][1] = term[i][2] + term[i][3];
      end
   end

   // result select, rounding and saturation
   always_comb begin
      sat_in = 1'b0;
      for (int i = 0; i < 4; i++) begin
         acc[i]   = hp_ff[i][0] + hp_ff[i][1];
         rnd[i]   = acc[i] + 88'sd2147483648;
         rot_s[i] = pemu_pkg::sat_val(64'($signed(rnd[i][87:32])));
      end
      for (int i = 0; i < 3; i++) begin
         tr_s[i] = pemu_pkg::sat_val(64'($signed(st_ff[18].a[i]))
                                   + 64'($signed(st_ff[18].d[i])));
      end
      if (!st_ff[18].func) begin
         for (int i = 0; i < 3; i++) r_in[i] = tr_s[i].val;
         r_in[3] = '0;
         sat_in  = tr_s[0].clip | tr_s[1].clip | tr_s[2].clip;
      end else if (st_ff[18].n == '0) begin
         // zero rotation: quaternion passes through
         for (int i = 0; i < 4; i++) r_in[i] = st_ff[18].a[i];
      end else begin
         for (int i = 0; i < 4; i++) r_in[i] = rot_s[i].val;
         sat_in = rot_s[0].clip | rot_s[1].clip | rot_s[2].clip | rot_s[3].clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         sv_ff        <= sv_in;
         rsp_valid_ff <= sv_ff[18];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff  <= st_in;
         hp_ff  <= hp_in;
         r_ff   <= r_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_r0        = r_ff[0];
   assign rsp_r1        = r_ff[1];
   assign rsp_r2        = r_ff[2];
   assign rsp_r3        = r_ff[3];
   assign rsp_saturated = sat_ff;

   // ---------------- assertions
   a_trans_r3_zero: assert property (@(posedge clock) disable iff (reset)
      adv && sv_ff[18] && !st_ff[18].func |=> rsp_r3 == '0)
      else $error("translation result has nonzero r3");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(st_ff[3]) && $stable(sv_ff))
      else $error("pipeline moved while output stalled");

   a_angle_folded: assert property (@(posedge clock) disable iff (reset)
      sv_ff[6] |-> st_ff[6].cz <= pemu_pkg::HALF_PI_Q60)
      else $error("CORDIC angle outside first quadrant");

endmodule
